@@ src/modular_exponentiation_assert.svh @@
// Assertion macros shared by the modular exponentiation RTL.
// Included by the files that check their own logic; needs no package.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MEXP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("modular exponentiation check failed");
`define MEXP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("modular exponentiation check failed");
`else
`define MEXP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define MEXP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ src/mexp_pkg.sv @@
// Types, widths and codes for the modular exponentiation block.
// Has no dependencies; every other file but the assertion macro header imports it.
package mexp_pkg;

    localparam int WORD_BITS = 32;
    localparam int CNT_W     = $clog2(WORD_BITS);
    localparam int CFG_IDX_W = 2;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [CNT_W-1:0]     t_bit_cnt;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_MODULUS      = t_cfg_idx'(0);
    localparam t_cfg_idx REG_PUBLIC_EXP   = t_cfg_idx'(1);
    localparam t_cfg_idx REG_PRIVATE_EXP  = t_cfg_idx'(2);

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    localparam t_word MODULUS_RESET = t_word'(2);
    localparam t_word EXP_RESET     = t_word'(1);
    localparam t_word WORD_ONE      = t_word'(1);

    localparam t_bit_cnt LAST_BIT = t_bit_cnt'(WORD_BITS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_BIT,
        ST_MUL_ACC,
        ST_SQUARE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

endpackage

@@ src/mexp_if.sv @@
// Handshake channels of the modular exponentiation block: input items,
// result items and configuration writes. Depends on mexp_pkg.
interface mexp_item_if import mexp_pkg::*;;
    logic  valid;
    logic  ready;
    logic  cmd;
    t_word base_value;

    modport source (output valid, output cmd, output base_value, input ready);
    modport sink (input valid, input cmd, input base_value, output ready);
endinterface

interface mexp_result_if import mexp_pkg::*;;
    logic  valid;
    logic  ready;
    t_word result_value;

    modport source (output valid, output result_value, input ready);
    modport sink (input valid, input result_value, output ready);
endinterface

interface mexp_cfg_if import mexp_pkg::*;;
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_word    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/mexp_mulmod.sv @@
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
// Depends on mexp_pkg and the assertion macro header.
`include "modular_exponentiation_assert.svh"

module mexp_mulmod import mexp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_word     i_a,
    input  t_word     i_b,
    input  t_word     i_n,
    output t_word     o_product,
    output t_mul_stat o_stat
);

    localparam int EXT_W = WORD_BITS + 2;

    t_word      r_r, n_r;
    t_word      r_a, n_a;
    t_word      r_b, n_b;
    t_bit_cnt   r_cnt, n_cnt;
    logic       r_busy, n_busy;
    logic       r_done, n_done;

    logic [EXT_W-1:0] w_sum;
    logic [EXT_W-1:0] w_n1;
    logic [EXT_W-1:0] w_n2;
    t_word            w_step;

    always_comb begin
        w_n1  = {2'b00, i_n};
        w_n2  = {1'b0, i_n, 1'b0};
        w_sum = {1'b0, r_r, 1'b0} + (r_b[WORD_BITS-1] ? {2'b00, r_a} : '0);
        if (w_sum >= w_n2) begin
            w_step = t_word'(w_sum - w_n2);
        end else if (w_sum >= w_n1) begin
            w_step = t_word'(w_sum - w_n1);
        end else begin
            w_step = t_word'(w_sum);
        end
    end

    always_comb begin
        n_r    = r_r;
        n_a    = r_a;
        n_b    = r_b;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_r    = '0;
            n_a    = i_a;
            n_b    = i_b;
            n_cnt  = LAST_BIT;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_r   = w_step;
            n_b   = r_b << 1;
            n_cnt = r_cnt - t_bit_cnt'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_r   <= n_r;
        r_a   <= n_a;
        r_b   <= n_b;
        r_cnt <= n_cnt;
    end

    assign o_product   = r_r;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

    `MEXP_ASSERT_NOW(a_done_not_busy, i_clk, i_rst_n, r_done, !r_busy)
    `MEXP_ASSERT_NEXT(a_last_step_done, i_clk, i_rst_n, r_busy && (r_cnt == '0) && !i_start, r_done)
    `MEXP_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start, r_busy && !r_done)

endmodule

@@ src/mexp_seq.sv @@
// Square-and-multiply sequencer: scans the exponent from its least significant
// bit and drives the shared multiplier. Depends on mexp_pkg, mexp_if, macros.
`include "modular_exponentiation_assert.svh"

module mexp_seq import mexp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mexp_item_if.sink     i_item,
    mexp_result_if.source o_result,
    input  t_word         i_modulus,
    input  t_word         i_public_exp,
    input  t_word         i_private_exp,
    output logic          o_mul_start,
    output t_word         o_mul_a,
    output t_word         o_mul_b,
    input  t_word         i_mul_product,
    input  t_mul_stat     i_mul_stat
);

    t_state   r_state, n_state;
    t_word    r_acc, n_acc;
    t_word    r_sq, n_sq;
    t_word    r_exp, n_exp;
    t_bit_cnt r_bit, n_bit;
    t_word    r_out, n_out;
    logic     r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_acc <= n_acc;
        r_sq  <= n_sq;
        r_exp <= n_exp;
        r_bit <= n_bit;
        r_out <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_sq        = r_sq;
        n_exp       = r_exp;
        n_bit       = r_bit;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_mul_start = 1'b0;
        o_mul_a     = r_sq;
        o_mul_b     = r_sq;
        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                o_mul_a = WORD_ONE;
                o_mul_b = i_item.base_value;
                if (i_item.valid) begin
                    n_exp = (i_item.cmd == CMD_DECRYPT) ? i_private_exp : i_public_exp;
                    n_bit = '0;
                    if (i_modulus == '0) begin
                        n_acc   = '0;
                        n_state = ST_FINISH;
                    end else begin
                        n_acc       = (i_modulus == WORD_ONE) ? '0 : WORD_ONE;
                        o_mul_start = 1'b1;
                        n_state     = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                if (i_mul_stat.done) begin
                    n_sq    = i_mul_product;
                    n_state = ST_BIT;
                end
            end
            ST_BIT: begin
                o_mul_start = 1'b1;
                if (r_exp[0]) begin
                    o_mul_a = r_acc;
                    n_state = ST_MUL_ACC;
                end else begin
                    n_state = ST_SQUARE;
                end
            end
            ST_MUL_ACC: begin
                if (i_mul_stat.done) begin
                    n_acc       = i_mul_product;
                    o_mul_start = 1'b1;
                    n_state     = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                if (i_mul_stat.done) begin
                    n_sq  = i_mul_product;
                    n_exp = r_exp >> 1;
                    if (r_bit == LAST_BIT) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_bit   = r_bit + t_bit_cnt'(1);
                        n_state = ST_BIT;
                    end
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out       = r_acc;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign i_item.ready          = (r_state == ST_IDLE);
    assign o_result.valid        = r_out_valid;
    assign o_result.result_value = r_out;

    `MEXP_ASSERT_NOW(a_start_idle_unit, i_clk, i_rst_n, o_mul_start, !i_mul_stat.busy)
    `MEXP_ASSERT_NOW(a_acc_reduced, i_clk, i_rst_n, (r_state == ST_BIT) && (i_modulus > WORD_ONE), r_acc < i_modulus)
    `MEXP_ASSERT_NOW(a_sq_reduced, i_clk, i_rst_n, (r_state == ST_BIT) && (i_modulus > WORD_ONE), r_sq < i_modulus)
    `MEXP_ASSERT_NOW(a_unit_busy_in_wait, i_clk, i_rst_n, (r_state == ST_SQUARE) && !i_mul_stat.done, i_mul_stat.busy)

endmodule

@@ src/modular_exponentiation.sv @@
// Top level of the modular exponentiation block: configuration registers,
// sequencer and shared multiplier. Depends on mexp_pkg, mexp_if, mexp_seq, mexp_mulmod.
//
// Each input item returns base_value raised to the public exponent (cmd 0) or the
// private exponent (cmd 1), reduced modulo the modulus register; a modulus of zero
// gives 0. The work runs on one bit-serial modular multiplier: one product reduces
// the base, then each of the 32 exponent bits costs a decision step, a squaring and,
// for a set bit, a multiply into the accumulator. The input is not ready while an
// item is worked on. A finished result waits in an output register, so the next
// item is taken while it is still unread. Configuration writes are always accepted
// and must only be made while the block is idle.
module modular_exponentiation import mexp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mexp_item_if.sink     i_item,
    mexp_result_if.source o_result,
    mexp_cfg_if.sink      i_cfg
);

    t_word     r_modulus;
    t_word     r_public_exp;
    t_word     r_private_exp;
    logic      w_mul_start;
    t_word     w_mul_a;
    t_word     w_mul_b;
    t_word     w_mul_product;
    t_mul_stat w_mul_stat;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus     <= MODULUS_RESET;
            r_public_exp  <= EXP_RESET;
            r_private_exp <= EXP_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_MODULUS:     r_modulus     <= i_cfg.data;
                REG_PUBLIC_EXP:  r_public_exp  <= i_cfg.data;
                REG_PRIVATE_EXP: r_private_exp <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    mexp_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (i_item),
        .o_result      (o_result),
        .i_modulus     (r_modulus),
        .i_public_exp  (r_public_exp),
        .i_private_exp (r_private_exp),
        .o_mul_start   (w_mul_start),
        .o_mul_a       (w_mul_a),
        .o_mul_b       (w_mul_b),
        .i_mul_product (w_mul_product),
        .i_mul_stat    (w_mul_stat)
    );

    mexp_mulmod u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_a       (w_mul_a),
        .i_b       (w_mul_b),
        .i_n       (r_modulus),
        .o_product (w_mul_product),
        .o_stat    (w_mul_stat)
    );

endmodule
